@@ hw/rtl/mdsrl_pkg.sv @@
// Shared constants, types and codes for the message dedup and sender rate limit core.
`default_nettype none
package mdsrl_pkg;

    localparam int RECENT_DEPTH   = 8;
    localparam int SENDER_ENTRIES = 4;

    localparam int PTR_W  = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
    localparam int SLOT_W = (SENDER_ENTRIES > 1) ? $clog2(SENDER_ENTRIES) : 1;

    localparam int ID_W       = 64;
    localparam int HASH_W     = 64;
    localparam int TIME_W     = 32;
    localparam int COOLDOWN_W = 20;
    localparam int VERDICT_W  = 2;
    localparam int OUT_SLOT_W = 2;

    localparam int S_TDATA_W = 224;
    localparam int M_TDATA_W = 8;

    localparam logic [COOLDOWN_W-1:0] COOLDOWN_RESET = COOLDOWN_W'(15000);

    localparam int  PADDR_W      = 3;
    localparam logic REG_COOLDOWN = 1'b0;   // register index, paddr[2]

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_ACCEPT    = 2'd0,
        VERDICT_DUPLICATE = 2'd1,
        VERDICT_COOLDOWN  = 2'd2
    } verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ID_CHECK,
        ST_LOOKUP,
        ST_PICK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;    // latch the input item
        logic id_check;   // search the id ring, record on miss
        logic lookup;     // compare sender table, compute ages
        logic pick;       // choose slot, update sender table
        logic load_out;   // move the result into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic id_hit;
    } dp_status_t;

endpackage
`default_nettype wire

@@ hw/rtl/message_dedup_and_sender_rate_limit_core.sv @@
// Top level: stream ports, APB cooldown register, controller and datapath.
`default_nettype none
// Duplicate filter with per-sender rate limiting. Each input item is one message; each
// gives exactly one result item with a verdict (0 accepted, 1 duplicate, 2 sender in
// cooldown) and the sender table slot used. The id is compared against the last 8 ids
// at once; a miss records it. Senders live in a 4-entry table; unknown senders take the
// first free slot or evict the oldest. Items are handled one at a time: a duplicate
// goes through accept, id check and result load, any other message through accept, id
// check, table compare, slot pick and update, and result load, set by the controller
// sequence. The result register is loaded in the last step; a result still waiting
// there holds the sequence in its last step until it is taken.
// The result register lets the next item be accepted while a result waits. After reset
// the id ring holds zeros, so an all-zero id is reported as a duplicate. The user must
// write cooldown_ms (APB address 0, 20 bits, reset 15000) only while idle; not enforced.
module message_dedup_and_sender_rate_limit_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // message_id [63:0], sender_high [127:64], sender_low [191:128], now_ms [223:192]
    input  wire logic [mdsrl_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // verdict [1:0], sender_slot [3:2], zero [7:4]
    output logic [mdsrl_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mdsrl_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);
    import mdsrl_pkg::*;

    logic [COOLDOWN_W-1:0] cooldown_reg;
    logic [COOLDOWN_W-1:0] cooldown_next;
    dp_cmd_t               cmd;
    dp_status_t            status;
    logic [VERDICT_W-1:0]  out_verdict;
    logic [OUT_SLOT_W-1:0] out_sender_slot;

    assign pready = 1'b1;

    always_comb begin
        cooldown_next = cooldown_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_COOLDOWN))
            cooldown_next = pwdata[COOLDOWN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            cooldown_reg <= COOLDOWN_RESET;
        else
            cooldown_reg <= cooldown_next;
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_COOLDOWN)
            prdata = {{(32-COOLDOWN_W){1'b0}}, cooldown_reg};
    end

    mdsrl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mdsrl_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_message_id   (s_tdata[63:0]),
        .in_sender_high  (s_tdata[127:64]),
        .in_sender_low   (s_tdata[191:128]),
        .in_now_ms       (s_tdata[223:192]),
        .cooldown_ms     (cooldown_reg),
        .cmd             (cmd),
        .status          (status),
        .out_verdict     (out_verdict),
        .out_sender_slot (out_sender_slot)
    );

    assign m_tdata = {{(M_TDATA_W-VERDICT_W-OUT_SLOT_W){1'b0}}, out_sender_slot, out_verdict};

endmodule
`default_nettype wire

@@ hw/rtl/mdsrl_ctrl.sv @@
// Controller state machine: sequences one item through the datapath and owns the handshakes.
`default_nettype none
module mdsrl_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire mdsrl_pkg::dp_status_t status,
    output mdsrl_pkg::dp_cmd_t        cmd
);
    import mdsrl_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_ID_CHECK;
            end
            ST_ID_CHECK: begin
                state_next = status.id_hit ? ST_DONE : ST_LOOKUP;
            end
            ST_LOOKUP: state_next = ST_PICK;
            ST_PICK:   state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // no item is taken while reset is held
                s_tready    = aresetn;
                cmd.capture = s_tvalid;
            end
            ST_ID_CHECK: cmd.id_check = 1'b1;
            ST_LOOKUP:   cmd.lookup   = 1'b1;
            ST_PICK:     cmd.pick     = 1'b1;
            ST_DONE:     cmd.load_out = out_free;
            default: begin
                cmd      = '0;
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire

@@ hw/rtl/mdsrl_dp.sv @@
// Datapath: id ring, sender table, age and cooldown logic, result registers.
`default_nettype none
module mdsrl_dp (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic [mdsrl_pkg::ID_W-1:0]            in_message_id,
    input  wire logic [mdsrl_pkg::HASH_W-1:0]          in_sender_high,
    input  wire logic [mdsrl_pkg::HASH_W-1:0]          in_sender_low,
    input  wire logic [mdsrl_pkg::TIME_W-1:0]          in_now_ms,
    input  wire logic [mdsrl_pkg::COOLDOWN_W-1:0]      cooldown_ms,
    input  wire mdsrl_pkg::dp_cmd_t                    cmd,
    output mdsrl_pkg::dp_status_t                      status,
    output logic [mdsrl_pkg::VERDICT_W-1:0]            out_verdict,
    output logic [mdsrl_pkg::OUT_SLOT_W-1:0]           out_sender_slot
);
    import mdsrl_pkg::*;

    // captured item
    logic [ID_W-1:0]   id_reg;
    logic [HASH_W-1:0] hi_reg;
    logic [HASH_W-1:0] lo_reg;
    logic [TIME_W-1:0] now_reg;

    // id ring
    logic [ID_W-1:0]  recent_ids_reg [RECENT_DEPTH];
    logic [PTR_W-1:0] ring_ptr_reg;
    logic             id_hit;

    // sender table
    logic [HASH_W-1:0] hash_high_reg [SENDER_ENTRIES];
    logic [HASH_W-1:0] hash_low_reg  [SENDER_ENTRIES];
    logic [TIME_W-1:0] last_ms_reg   [SENDER_ENTRIES];
    logic [SENDER_ENTRIES-1:0] valid_reg;

    // lookup results
    logic [SENDER_ENTRIES-1:0] match_reg;
    logic [TIME_W-1:0]         age_reg [SENDER_ENTRIES];

    // slot choice
    logic              found;
    logic [SLOT_W-1:0] match_slot;
    logic [SLOT_W-1:0] evict_slot;
    logic [SLOT_W-1:0] pick_slot;
    logic              free_seen;
    logic              in_cooldown;

    logic [VERDICT_W-1:0]      verdict_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic [SLOT_W+OUT_SLOT_W-1:0] slot_ext;

    always_comb begin
        id_hit = 1'b0;
        for (int i = 0; i < RECENT_DEPTH; i++) begin
            if (recent_ids_reg[i] == id_reg) id_hit = 1'b1;
        end
    end
    assign status.id_hit = id_hit;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            id_reg  <= in_message_id;
            hi_reg  <= in_sender_high;
            lo_reg  <= in_sender_low;
            now_reg <= in_now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RECENT_DEPTH; i++) recent_ids_reg[i] <= '0;
            ring_ptr_reg <= '0;
        end else if (cmd.id_check && !id_hit) begin
            recent_ids_reg[ring_ptr_reg] <= id_reg;
            if (ring_ptr_reg == PTR_W'(RECENT_DEPTH - 1))
                ring_ptr_reg <= '0;
            else
                ring_ptr_reg <= ring_ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            for (int i = 0; i < SENDER_ENTRIES; i++) begin
                match_reg[i] <= valid_reg[i] && (hash_high_reg[i] == hi_reg)
                                && (hash_low_reg[i] == lo_reg);
                age_reg[i]   <= now_reg - last_ms_reg[i];
            end
        end
    end

    // first matching slot
    always_comb begin
        found      = 1'b0;
        match_slot = '0;
        for (int i = SENDER_ENTRIES - 1; i >= 0; i--) begin
            if (match_reg[i]) begin
                found      = 1'b1;
                match_slot = SLOT_W'(i);
            end
        end
    end

    // first free slot, else oldest valid slot (lowest on a tie)
    always_comb begin
        evict_slot = '0;
        free_seen  = 1'b0;
        for (int i = 0; i < SENDER_ENTRIES; i++) begin
            if (!free_seen) begin
                if (!valid_reg[i]) begin
                    evict_slot = SLOT_W'(i);
                    free_seen  = 1'b1;
                end else if (age_reg[i] > age_reg[evict_slot]) begin
                    evict_slot = SLOT_W'(i);
                end
            end
        end
    end

    assign in_cooldown = found &&
                         (age_reg[match_slot] < {{(TIME_W-COOLDOWN_W){1'b0}}, cooldown_ms});
    assign pick_slot   = found ? match_slot : evict_slot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int i = 0; i < SENDER_ENTRIES; i++) last_ms_reg[i] <= '0;
        end else if (cmd.pick && !in_cooldown) begin
            last_ms_reg[pick_slot] <= now_reg;
            valid_reg[pick_slot]   <= 1'b1;
        end
    end

    // hash entries are only read behind their valid bit
    always_ff @(posedge aclk) begin
        if (cmd.pick && !found) begin
            hash_high_reg[evict_slot] <= hi_reg;
            hash_low_reg[evict_slot]  <= lo_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.id_check && id_hit) begin
            verdict_reg <= VERDICT_DUPLICATE;
            slot_reg    <= '0;
        end else if (cmd.pick) begin
            verdict_reg <= in_cooldown ? VERDICT_COOLDOWN : VERDICT_ACCEPT;
            slot_reg    <= pick_slot;
        end
    end

    assign slot_ext = {{OUT_SLOT_W{1'b0}}, slot_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_verdict     <= verdict_reg;
            out_sender_slot <= slot_ext[OUT_SLOT_W-1:0];
        end
    end

endmodule
`default_nettype wire
